// ===== design/wbps_pkg.sv =====
// ----------------------------------------------------------------------------
// Wildcard byte pattern search package
// Shared types and constants for the search cells, output buffer and top.
// ----------------------------------------------------------------------------
`default_nettype none

package wbps_pkg;

  localparam int unsigned CFG_IDX_W     = 3;
  localparam int unsigned CFG_DATA_W    = 64;
  localparam int unsigned LEN_W         = 6;
  localparam int unsigned RES_OFF_W     = 32;
  localparam int unsigned BYTES_PER_REG = 8;
  localparam int unsigned PAT_REGS      = 4;
  localparam int unsigned MAX_CELLS     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_PAT_LOW      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_MID_LOW  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_MID_HIGH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PAT_HIGH     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WILDCARD     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH       = 3'd5;

  typedef struct packed {
    logic       byte_we;
    logic [7:0] pat_byte;
    logic       wc_we;
    logic       wc_bit;
  } cell_cfg_t;

  typedef struct packed {
    logic       advance;
    logic       clear;
    logic [7:0] data;
  } cell_step_t;

  typedef struct packed {
    logic                 found;
    logic [RES_OFF_W-1:0] offset;
  } result_t;

endpackage

`default_nettype wire

// ===== design/wbps_cell.sv =====
// ----------------------------------------------------------------------------
// Pattern search cell
// Holds one pattern position and its partial match bit; passes the bit on.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_cell
  import wbps_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire cell_cfg_t  cfg_i,
  input  wire cell_step_t step_i,
  input  wire logic       in_use_i,
  input  wire logic       chain_i,
  output logic            chain_o,
  output logic            next_o
);

  logic [7:0] pat_q;
  logic       wc_q;
  logic       bit_q;
  logic       bit_d;

  assign next_o  = chain_i & in_use_i & (wc_q | (pat_q == step_i.data));
  assign chain_o = bit_q;

  always_comb begin
    bit_d = bit_q;
    if (step_i.clear) begin
      bit_d = 1'b0;
    end else if (step_i.advance) begin
      bit_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pat_q <= '0;
      wc_q  <= 1'b0;
      bit_q <= 1'b0;
    end else begin
      if (cfg_i.byte_we) begin
        pat_q <= cfg_i.pat_byte;
      end
      if (cfg_i.wc_we) begin
        wc_q <= cfg_i.wc_bit;
      end
      bit_q <= bit_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/wbps_out_buf.sv =====
// ----------------------------------------------------------------------------
// Result output buffer
// Output register plus skid stage; ready towards the input is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module wbps_out_buf
  import wbps_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    push_i,
  input  wire result_t res_i,
  output logic         ready_o,
  output logic         valid_o,
  input  wire logic    take_i,
  output result_t      res_o
);

  result_t out_q, out_d;
  result_t skid_q, skid_d;
  logic    out_v_q, out_v_d;
  logic    skid_v_q, skid_v_d;
  logic    pop;

  assign pop     = out_v_q & take_i;
  assign ready_o = ~skid_v_q;
  assign valid_o = out_v_q;
  assign res_o   = out_q;

  always_comb begin
    out_d    = out_q;
    out_v_d  = out_v_q;
    skid_d   = skid_q;
    skid_v_d = skid_v_q;
    if (skid_v_q) begin
      if (pop) begin
        out_d    = skid_q;
        skid_v_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_v_q || pop) begin
        out_d   = res_i;
        out_v_d = 1'b1;
      end else begin
        skid_d   = res_i;
        skid_v_d = 1'b1;
      end
    end else if (pop) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

endmodule

`default_nettype wire

// ===== design/wildcard_byte_pattern_search.sv =====
// Throughput: one region byte per cycle while the skid stage is empty;
// until a match is reported, every cell of the chain updates its partial
// match bit in the same cycle as the byte is taken.
// Reset: pattern bytes and wildcard mask clear, length goes to one, match
// bits, byte count and the reported flag clear, output buffer empties.
// ----------------------------------------------------------------------------
// Wildcard byte pattern search
// Shift-and chain of cells finding the first wildcard pattern match in a
// streamed region; reports the first match offset or not found at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module wildcard_byte_pattern_search
  import wbps_pkg::*;
#(
  parameter int unsigned MAX_PATTERN = 32,
  parameter int unsigned OFFSET_BITS = 32
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [7:0]            s_axis_tdata,  // [7:0] data_byte
  input  wire logic                  s_axis_tlast,
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [RES_OFF_W-1:0]       m_axis_tdata,  // [31:0] match_offset
  output logic                       m_axis_tuser   // [0] found
);

  localparam int unsigned CELLS  = (MAX_PATTERN < MAX_CELLS) ? MAX_PATTERN : MAX_CELLS;
  localparam int unsigned CIDX_W = $clog2(CELLS);

  logic [LEN_W-1:0]       len_q, len_d, len_eff, len_m1;
  logic [OFFSET_BITS-1:0] cnt_q, cnt_d, len_m1_ext, off_full;
  logic                   reported_q, reported_d;
  logic [PAT_REGS-1:0]    pat_we;
  logic                   wc_we, len_we;
  logic                   acc, hit, push;
  logic [CELLS-1:0]       in_use, chain_q, next_bits;
  logic [CELLS-1:0]       chain_in;
  cell_step_t             step;
  result_t                res;
  result_t                res_out;

  always_comb begin
    pat_we = '0;
    wc_we  = 1'b0;
    len_we = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_PAT_LOW:      pat_we[0] = 1'b1;
        REG_PAT_MID_LOW:  pat_we[1] = 1'b1;
        REG_PAT_MID_HIGH: pat_we[2] = 1'b1;
        REG_PAT_HIGH:     pat_we[3] = 1'b1;
        REG_WILDCARD:     wc_we     = 1'b1;
        REG_LENGTH:       len_we    = 1'b1;
        default: ;
      endcase
    end
  end

  always_comb begin
    len_eff = len_q;
    if (len_q == '0) begin
      len_eff = LEN_W'(1);
    end else if (len_q > LEN_W'(CELLS)) begin
      len_eff = LEN_W'(CELLS);
    end
  end

  assign len_m1 = len_eff - LEN_W'(1);
  assign acc    = s_axis_tvalid & s_axis_tready;

  assign step.advance = acc & ~reported_q;
  assign step.clear   = acc & s_axis_tlast;
  assign step.data    = s_axis_tdata;

  assign chain_in = {chain_q[CELLS-2:0], 1'b1};

  for (genvar j = 0; j < CELLS; j++) begin : g_cell
    cell_cfg_t cell_cfg;

    assign cell_cfg.byte_we  = pat_we[j / BYTES_PER_REG];
    assign cell_cfg.pat_byte = cfg_wdata_i[8 * (j % BYTES_PER_REG) +: 8];
    assign cell_cfg.wc_we    = wc_we;
    assign cell_cfg.wc_bit   = cfg_wdata_i[j];
    assign in_use[j]         = LEN_W'(j) < len_eff;

    wbps_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cfg_i    (cell_cfg),
      .step_i   (step),
      .in_use_i (in_use[j]),
      .chain_i  (chain_in[j]),
      .chain_o  (chain_q[j]),
      .next_o   (next_bits[j])
    );
  end

  assign hit = step.advance & next_bits[len_m1[CIDX_W-1:0]];

  assign len_m1_ext = OFFSET_BITS'(len_m1);
  assign off_full   = (cnt_q >= len_m1_ext) ? (cnt_q - len_m1_ext) : '0;

  assign push       = hit | (step.clear & ~reported_q);
  assign res.found  = hit;
  assign res.offset = hit ? RES_OFF_W'(off_full) : '0;

  always_comb begin
    cnt_d      = cnt_q;
    reported_d = reported_q;
    len_d      = len_q;
    if (len_we) begin
      len_d = cfg_wdata_i[LEN_W-1:0];
    end
    if (step.clear) begin
      cnt_d      = '0;
      reported_d = 1'b0;
    end else if (acc) begin
      if (cnt_q != '1) begin
        cnt_d = cnt_q + OFFSET_BITS'(1);
      end
      if (hit) begin
        reported_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q      <= LEN_W'(1);
      cnt_q      <= '0;
      reported_q <= 1'b0;
    end else begin
      len_q      <= len_d;
      cnt_q      <= cnt_d;
      reported_q <= reported_d;
    end
  end

  wbps_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .res_i   (res),
    .ready_o (s_axis_tready),
    .valid_o (m_axis_tvalid),
    .take_i  (m_axis_tready),
    .res_o   (res_out)
  );

  assign m_axis_tdata = res_out.offset;
  assign m_axis_tuser = res_out.found;

`ifndef SYNTHESIS
  a_not_found_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("not-found result carries a non-zero offset");

  a_silent_after_report : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && reported_q && !s_axis_tlast |-> !push)
    else $error("second result within one region");

  a_region_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && s_axis_tlast |=> cnt_q == '0 && !reported_q && chain_q == '0)
    else $error("region state not cleared after final byte");
`endif

endmodule

`default_nettype wire
